@@ sv/ubd_pkg.sv @@
// ----------------------------------------------------------------------------
// ubd_pkg
// types and constants shared by the baud divisor pipeline
// ----------------------------------------------------------------------------
package ubd_pkg;

   localparam int ClkW          = 32;
   localparam int BaudW         = 22;
   localparam int IntW          = 16;
   localparam int FracW         = 6;
   // quotient floor(4*clock/baud) needs int + frac bits when not saturated
   localparam int QuoW          = IntW + FracW;
   // dividend is the clock times four: two zero bits below it
   localparam int NumW          = ClkW + 2;
   // dividend bits left to shift in once the top bits seed the remainder
   localparam int LowW          = QuoW;
   localparam int SeedW         = NumW - LowW;
   localparam int StepsPerStage = 2;
   localparam int NumStages     = QuoW / StepsPerStage;
   // clock bits that sit above the quotient range, for the saturation check
   localparam int ClkHiLsb      = QuoW - 2;

   localparam logic [IntW-1:0]  IntMax  = 16'hffff;
   localparam logic [IntW-1:0]  IntMin  = 16'h0001;
   localparam logic [FracW-1:0] FracMax = 6'h3f;

   typedef struct packed {
      logic [ClkW-1:0]  reference_clock;
      logic [BaudW-1:0] baud_rate;
   } ubd_req_type;

   typedef struct packed {
      logic [IntW-1:0]  integer_divisor;
      logic [FracW-1:0] fractional_divisor;
      logic             out_of_range;
   } ubd_rsp_type;

   // one item in flight through the divider
   typedef struct packed {
      logic             valid;
      logic             sat_high;
      logic [BaudW-1:0] rem;
      logic [LowW-1:0]  num;
      logic [QuoW-1:0]  quo;
      logic [BaudW-1:0] baud;
   } ubd_stage_type;

endpackage

@@ sv/ubd_prep.sv @@
// ----------------------------------------------------------------------------
// ubd_prep
// first pipeline stage: seeds the remainder and flags an oversized divisor
// ----------------------------------------------------------------------------
module ubd_prep import ubd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          req_valid,
   input  ubd_req_type   req_item,
   output ubd_stage_type stage_out
);

   ubd_stage_type stage_ff;
   ubd_stage_type stage_in;
   logic [NumW-1:0] dividend;

   always_comb begin
      dividend          = {req_item.reference_clock, 2'b00};
      stage_in.valid    = req_valid;
      // integer part above the maximum (or zero baud) when clock>>20 >= baud
      stage_in.sat_high = {{(BaudW-(ClkW-ClkHiLsb)){1'b0}},
                           req_item.reference_clock[ClkW-1:ClkHiLsb]}
                          >= req_item.baud_rate;
      stage_in.rem      = {{(BaudW-SeedW){1'b0}}, dividend[NumW-1:LowW]};
      stage_in.num      = dividend[LowW-1:0];
      stage_in.quo      = '0;
      stage_in.baud     = req_item.baud_rate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

@@ sv/ubd_stage.sv @@
// ----------------------------------------------------------------------------
// ubd_stage
// one divider stage: two restoring shift-subtract steps, then a register
// ----------------------------------------------------------------------------
module ubd_stage import ubd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  ubd_stage_type stage_in,
   output ubd_stage_type stage_out
);

   ubd_stage_type stage_ff;
   ubd_stage_type stage_nx;

   always_comb begin
      logic [BaudW:0] trial;
      stage_nx = stage_in;
      for (int s = 0; s < StepsPerStage; s++) begin
         trial        = {stage_nx.rem, stage_nx.num[LowW-1]};
         stage_nx.num = {stage_nx.num[LowW-2:0], 1'b0};
         if (trial >= {1'b0, stage_nx.baud}) begin
            trial        = trial - {1'b0, stage_nx.baud};
            stage_nx.quo = {stage_nx.quo[QuoW-2:0], 1'b1};
         end else begin
            stage_nx.quo = {stage_nx.quo[QuoW-2:0], 1'b0};
         end
         // remainder is below the baud rate again, so it fits
         stage_nx.rem = trial[BaudW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff <= stage_nx;
      end
   end

   assign stage_out = stage_ff;

endmodule

@@ sv/uart_baud_divisor_calc.sv @@
// ----------------------------------------------------------------------------
// uart_baud_divisor_calc
// fractional baud divisor for a 16x oversampling uart
// ----------------------------------------------------------------------------
// Each item carries a reference clock in hertz and a baud rate; the result is
// the divisor clock/(16*baud) as a 16-bit integer part and a 6-bit fraction in
// sixty-fourths, truncated, so integer*64+fraction = floor(4*clock/baud). An
// integer part of zero gives 1 and one above 65535 (or a zero baud rate) gives
// 65535, both with fraction 0 and out_of_range set. One item is taken in every
// cycle while req_stall is low; the pipeline is one seed stage, 11 divider
// stages of two restoring steps each (22 quotient bits) and the output register.
// The whole pipeline holds while a result is stalled, so req_stall follows
// rsp_stall whenever a result is waiting.
module uart_baud_divisor_calc import ubd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ubd_req_type req_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ubd_rsp_type rsp_item
);

   // pipeline moves as one when the output register can take a new item
   logic          advance;
   ubd_stage_type pipe [NumStages+1];
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   ubd_rsp_type   rsp_item_ff;
   ubd_rsp_type   rsp_item_in;
   logic [IntW-1:0] whole;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // seed stage
   ubd_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_valid (req_valid),
      .req_item  (req_item),
      .stage_out (pipe[0])
   );

   // divider stages
   for (genvar g = 0; g < NumStages; g++) begin : g_stage
      ubd_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (pipe[g]),
         .stage_out (pipe[g+1])
      );
   end

   // saturation and formatting of the result item
   always_comb begin
      whole        = pipe[NumStages].quo[QuoW-1:FracW];
      rsp_valid_in = pipe[NumStages].valid;
      priority if (pipe[NumStages].sat_high) begin
         // divisor too large, or zero baud rate
         rsp_item_in.integer_divisor    = IntMax;
         rsp_item_in.fractional_divisor = '0;
         rsp_item_in.out_of_range       = 1'b1;
      end else if (whole == '0) begin
         // clock below sixteen times the baud rate
         rsp_item_in.integer_divisor    = IntMin;
         rsp_item_in.fractional_divisor = '0;
         rsp_item_in.out_of_range       = 1'b1;
      end else begin
         rsp_item_in.integer_divisor    = whole;
         rsp_item_in.fractional_divisor = pipe[NumStages].quo[FracW-1:0] & FracMax;
         rsp_item_in.out_of_range       = 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
